// ===== rtl/core/crtc_raster_timing_with_registers_macros.svh =====
// Assertion macros for the CRTC raster timing block.
`ifndef CRTC_RASTER_TIMING_WITH_REGISTERS_MACROS_SVH
`define CRTC_RASTER_TIMING_WITH_REGISTERS_MACROS_SVH

// Same-cycle implication, gated by reset.
`define CRTC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crtc assertion failed");

// Next-cycle implication, gated by reset.
`define CRTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crtc assertion failed");

`endif

// ===== rtl/core/crtc_rt_pkg.sv =====
package crtc_rt_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  localparam logic [3:0] PORT_INDEX = 4'd4;
  localparam logic [3:0] PORT_DATA  = 4'd5;
  localparam logic [3:0] PORT_ARRAY = 4'd10;

  localparam int unsigned CRTC_REGS = 18;

  localparam logic [4:0] REG_HDISP     = 5'd1;
  localparam logic [4:0] REG_VTOTAL    = 5'd4;
  localparam logic [4:0] REG_VADJ      = 5'd5;
  localparam logic [4:0] REG_VDISP     = 5'd6;
  localparam logic [4:0] REG_VSYNC     = 5'd7;
  localparam logic [4:0] REG_INTERLACE = 5'd8;
  localparam logic [4:0] REG_MAXSCAN   = 5'd9;
  localparam logic [4:0] REG_CUR_START = 5'd10;
  localparam logic [4:0] REG_CUR_END   = 5'd11;
  localparam logic [4:0] REG_START_HI  = 5'd12;
  localparam logic [4:0] REG_START_LO  = 5'd13;

  localparam logic [7:0] STAT_DISPLAY = 8'h01;
  localparam logic [7:0] STAT_VSYNC   = 8'h08;
  localparam logic [7:0] STAT_TOGGLE  = 8'h10;

  typedef struct packed {
    opcode_e    opcode;
    logic [3:0] port;
    logic [7:0] wdata;
  } in_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [7:0]  status;
    logic [15:0] mem_address;
    logic [4:0]  scanline;
    logic [6:0]  row_count;
    logic        display_enable;
    logic        cursor_visible;
    logic        vsync_irq;
  } out_t;

  function automatic logic [7:0] reg_mask(input logic [4:0] sel);
    logic [7:0] m;
    case (sel)
      5'd4, 5'd6, 5'd7, 5'd10: m = 8'h7f;
      5'd5, 5'd9, 5'd11:       m = 8'h1f;
      5'd8:                    m = 8'hf3;
      5'd12, 5'd14:            m = 8'h3f;
      default:                 m = 8'hff;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/crtc_raster_timing_with_registers.sv =====
// The result transaction is registered: it follows its input transaction in the next cycle.
// Throughput: one transaction per cycle; the result register frees as it is taken.
// Input stalls only while a result waits and the receiver stalls it.
// Reset (rst_ni low, asynchronous) clears the register file, palette, counters and result valid.
`include "crtc_raster_timing_with_registers_macros.svh"

module crtc_raster_timing_with_registers #(
  parameter int unsigned VSYNC_HALF_LINES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  crtc_rt_pkg::in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output crtc_rt_pkg::out_t out_data_o
);

  logic [7:0]  file_q [crtc_rt_pkg::CRTC_REGS];
  logic [7:0]  pal_q  [32];
  logic [4:0]  csel_q, csel_d;
  logic [4:0]  asel_q, asel_d;
  logic        aphase_q, aphase_d;
  logic [7:0]  status_q, status_d;
  logic        half_q, half_d;
  logic [4:0]  line_q, line_d;
  logic [6:0]  row_q, row_d;
  logic [15:0] addr_q, addr_d;
  logic [15:0] rsa_q, rsa_d;
  logic        disp_q, disp_d;
  logic [4:0]  adj_q, adj_d;
  logic [4:0]  sync_q, sync_d;
  logic        curline_q, curline_d;
  logic        curblink_q, curblink_d;
  logic [4:0]  blinkcnt_q, blinkcnt_d;

  logic        file_we, pal_we;
  logic [7:0]  file_wdata, pal_wdata;

  logic        out_valid_q;
  crtc_rt_pkg::out_t out_q, out_d;
  logic        accept;
  logic        tick_first, status_rd;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign tick_first = accept && (in_data_i.opcode == crtc_rt_pkg::OP_TICK) && !half_q;
  assign status_rd  = accept && (in_data_i.opcode == crtc_rt_pkg::OP_READ) &&
                      (in_data_i.port == crtc_rt_pkg::PORT_ARRAY);

  function automatic logic line_match(input logic [4:0] ln, input logic [7:0] tgt,
                                      input logic il);
    return (ln == tgt[4:0]) || (il && (ln == {1'b0, tgt[4:1]}));
  endfunction

  always_comb begin
    logic        il;
    logic        adv;
    logic [8:0]  mode;
    logic [15:0] sa;
    logic [4:0]  ln;
    logic [6:0]  rn;
    logic        irq;
    logic [7:0]  rd;

    csel_d     = csel_q;
    asel_d     = asel_q;
    aphase_d   = aphase_q;
    status_d   = status_q;
    half_d     = half_q;
    line_d     = line_q;
    row_d      = row_q;
    addr_d     = addr_q;
    rsa_d      = rsa_q;
    disp_d     = disp_q;
    adj_d      = adj_q;
    sync_d     = sync_q;
    curline_d  = curline_q;
    curblink_d = curblink_q;
    blinkcnt_d = blinkcnt_q;
    file_we    = 1'b0;
    pal_we     = 1'b0;
    file_wdata = in_data_i.wdata & crtc_rt_pkg::reg_mask(csel_q);
    pal_wdata  = asel_q[4] ? {4'h0, in_data_i.wdata[3:0]} : in_data_i.wdata;
    irq        = 1'b0;
    rd         = 8'h00;
    ln         = line_q;
    rn         = row_q;

    il   = (file_q[crtc_rt_pkg::REG_INTERLACE][1:0] == 2'b11);
    mode = {pal_q[3][3], 3'b000, pal_q[0][4], 2'b00, pal_q[0][1:0]};
    case (mode) inside
      9'h000, 9'h001, 9'h002, 9'h003, 9'h012, 9'h013, 9'h102: adv = 1'b1;
      default:                                                adv = 1'b0;
    endcase
    sa = {2'b00, file_q[crtc_rt_pkg::REG_START_HI][5:0],
          file_q[crtc_rt_pkg::REG_START_LO]};

    case (in_data_i.opcode)
      crtc_rt_pkg::OP_WRITE: begin
        case (in_data_i.port)
          crtc_rt_pkg::PORT_INDEX: csel_d = in_data_i.wdata[4:0];
          crtc_rt_pkg::PORT_DATA: begin
            file_we = (csel_q < 5'(crtc_rt_pkg::CRTC_REGS));
          end
          crtc_rt_pkg::PORT_ARRAY: begin
            if (!aphase_q) begin
              asel_d = in_data_i.wdata[4:0];
            end else begin
              pal_we = 1'b1;
            end
            aphase_d = ~aphase_q;
          end
          default: ;
        endcase
      end
      crtc_rt_pkg::OP_READ: begin
        case (in_data_i.port)
          crtc_rt_pkg::PORT_INDEX: rd = {3'b000, csel_q};
          crtc_rt_pkg::PORT_DATA: begin
            rd = (csel_q < 5'(crtc_rt_pkg::CRTC_REGS)) ? file_q[csel_q] : 8'h00;
          end
          crtc_rt_pkg::PORT_ARRAY: begin
            aphase_d = 1'b0;
            status_d = status_q ^ crtc_rt_pkg::STAT_TOGGLE;
            rd       = status_d;
          end
          default: rd = 8'hff;
        endcase
      end
      crtc_rt_pkg::OP_TICK: begin
        if (!half_q) begin
          half_d      = 1'b1;
          status_d[0] = 1'b0;
          if (disp_q && adv) begin
            addr_d = addr_q + {8'h00, file_q[crtc_rt_pkg::REG_HDISP]};
          end
          if (row_q == file_q[crtc_rt_pkg::REG_VSYNC][6:0] && line_q == 5'd0) begin
            status_d[3] = 1'b1;
          end
        end else begin
          half_d = 1'b0;
          if (disp_q) begin
            status_d[0] = 1'b1;
          end
          if (sync_q != 5'd0) begin
            sync_d = sync_q - 5'd1;
            if (sync_q == 5'd1) begin
              status_d[3] = 1'b0;
            end
          end
          if (line_match(line_q, file_q[crtc_rt_pkg::REG_CUR_END], il)) begin
            curline_d = 1'b0;
          end
          if (adj_q != 5'd0) begin
            ln     = line_q + 5'd1;
            addr_d = rsa_q;
            adj_d  = adj_q - 5'd1;
            if (adj_q == 5'd1) begin
              disp_d = 1'b1;
              addr_d = sa;
              rsa_d  = sa;
              ln     = 5'd0;
            end
          end else if (line_match(line_q, file_q[crtc_rt_pkg::REG_MAXSCAN], il)) begin
            rsa_d = addr_q;
            ln    = 5'd0;
            rn    = row_q + 7'd1;
            if (rn == file_q[crtc_rt_pkg::REG_VDISP][6:0]) begin
              disp_d = 1'b0;
            end
            if (row_q == file_q[crtc_rt_pkg::REG_VTOTAL][6:0]) begin
              rn    = 7'd0;
              adj_d = file_q[crtc_rt_pkg::REG_VADJ][4:0];
              if (file_q[crtc_rt_pkg::REG_VADJ][4:0] == 5'd0) begin
                disp_d = 1'b1;
                addr_d = sa;
                rsa_d  = sa;
              end
              if ((file_q[crtc_rt_pkg::REG_CUR_START] & 8'h60) == 8'h20) begin
                curblink_d = 1'b0;
              end else begin
                curblink_d = blinkcnt_q[4];
              end
            end
            if (rn == file_q[crtc_rt_pkg::REG_VSYNC][6:0]) begin
              disp_d     = 1'b0;
              sync_d     = 5'(VSYNC_HALF_LINES);
              irq        = 1'b1;
              blinkcnt_d = blinkcnt_q + 5'd1;
            end
          end else begin
            ln     = line_q + 5'd1;
            addr_d = rsa_q;
          end
          row_d  = rn;
          line_d = ln;
          if (line_match(ln, file_q[crtc_rt_pkg::REG_CUR_START], il)) begin
            curline_d = 1'b1;
          end
        end
      end
      default: ;
    endcase

    out_d.rdata          = rd;
    out_d.status         = status_d;
    out_d.mem_address    = addr_d;
    out_d.scanline       = line_d;
    out_d.row_count      = row_d;
    out_d.display_enable = disp_d;
    out_d.cursor_visible = curline_d & curblink_d;
    out_d.vsync_irq      = irq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(crtc_rt_pkg::CRTC_REGS); i++) file_q[i] <= 8'h00;
      for (int i = 0; i < 32; i++) pal_q[i] <= 8'h00;
      csel_q     <= '0;
      asel_q     <= '0;
      aphase_q   <= 1'b0;
      status_q   <= '0;
      half_q     <= 1'b0;
      line_q     <= '0;
      row_q      <= '0;
      addr_q     <= '0;
      rsa_q      <= '0;
      disp_q     <= 1'b0;
      adj_q      <= '0;
      sync_q     <= '0;
      curline_q  <= 1'b0;
      curblink_q <= 1'b0;
      blinkcnt_q <= '0;
    end else if (accept) begin
      if (file_we) file_q[csel_q] <= file_wdata;
      if (pal_we)  pal_q[asel_q]  <= pal_wdata;
      csel_q     <= csel_d;
      asel_q     <= asel_d;
      aphase_q   <= aphase_d;
      status_q   <= status_d;
      half_q     <= half_d;
      line_q     <= line_d;
      row_q      <= row_d;
      addr_q     <= addr_d;
      rsa_q      <= rsa_d;
      disp_q     <= disp_d;
      adj_q      <= adj_d;
      sync_q     <= sync_d;
      curline_q  <= curline_d;
      curblink_q <= curblink_d;
      blinkcnt_q <= blinkcnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  `CRTC_ASSERT_IMP(a_irq_blanks, out_valid_o && out_data_o.vsync_irq, !out_data_o.display_enable)
  `CRTC_ASSERT_NEXT(a_first_phase, tick_first, half_q && !out_q.vsync_irq)
  `CRTC_ASSERT_NEXT(a_status_toggle, status_rd, out_q.status[4] != $past(status_q[4]) && !aphase_q)

endmodule

// ===== verif/crtc_raster_timing_with_registers_tb.sv =====
module crtc_raster_timing_with_registers_tb;
  import crtc_rt_pkg::*;

  localparam int unsigned VSYNC_HALF_LINES = 16;

  class crtc_scoreboard;
    logic [7:0]  regs [CRTC_REGS];
    logic [7:0]  reg_bits [CRTC_REGS];
    logic [4:0]  crtc_sel;
    logic [7:0]  palette [32];
    logic [4:0]  pal_sel;
    logic        pal_phase;
    logic [7:0]  status;
    logic        half;
    logic [4:0]  scan;
    logic [6:0]  row;
    logic [15:0] addr;
    logic [15:0] row_start;
    logic        disp;
    logic [4:0]  adjust;
    logic [4:0]  sync;
    logic [4:0]  sync_reload;
    logic [4:0]  blink;
    logic        cur_line;
    logic        cur_blink;
    out_t        due_results[$];
    int unsigned errors;

    function new(int unsigned sync_len);
      reg_bits = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h1f, 8'h7f, 8'h7f, 8'hf3,
                   8'h1f, 8'h7f, 8'h1f, 8'h3f, 8'hff, 8'h3f, 8'hff, 8'hff, 8'hff};
      foreach (regs[i]) regs[i] = 8'h00;
      foreach (palette[i]) palette[i] = 8'h00;
      sync_reload = sync_len[4:0];
      crtc_sel = '0;
      pal_sel = '0;
      pal_phase = 1'b0;
      status = '0;
      half = 1'b0;
      scan = '0;
      row = '0;
      addr = '0;
      row_start = '0;
      disp = 1'b0;
      adjust = '0;
      sync = '0;
      blink = '0;
      cur_line = 1'b0;
      cur_blink = 1'b0;
      errors = 0;
    endfunction

    function bit interlaced();
      return regs[REG_INTERLACE][1:0] == 2'b11;
    endfunction

    // interlace also matches at half the programmed line
    function bit scan_match(logic [7:0] target);
      logic [4:0] t;
      t = target[4:0];
      return scan == t || (interlaced() && scan == (t >> 1));
    endfunction

    // mode code {pal3[3], pal0[4], pal0[1:0]}: text and low-res modes advance
    function bit mode_advances();
      if (palette[3][3])
        return palette[0][1] && !palette[0][0] && !palette[0][4];
      return !(palette[0][4] && !palette[0][1]);
    endfunction

    function logic [15:0] start_addr();
      return {regs[REG_START_HI], regs[REG_START_LO]} & 16'h3fff;
    endfunction

    function void bus_write(logic [3:0] p, logic [7:0] v);
      if (p == PORT_INDEX) begin
        crtc_sel = v[4:0];
      end else if (p == PORT_DATA) begin
        if (crtc_sel < CRTC_REGS) regs[crtc_sel] = v & reg_bits[crtc_sel];
      end else if (p == PORT_ARRAY) begin
        if (!pal_phase) pal_sel = v[4:0];
        else palette[pal_sel] = pal_sel[4] ? {4'h0, v[3:0]} : v;
        pal_phase = ~pal_phase;
      end
    endfunction

    function logic [7:0] bus_read(logic [3:0] p);
      if (p == PORT_INDEX) return {3'b000, crtc_sel};
      if (p == PORT_DATA) return (crtc_sel < CRTC_REGS) ? regs[crtc_sel] : 8'h00;
      if (p == PORT_ARRAY) begin
        pal_phase = 1'b0;
        status ^= STAT_TOGGLE;
        return status;
      end
      return 8'hff;
    endfunction

    function bit half_line_tick();
      logic [6:0] prev;
      bit irq;
      irq = 1'b0;
      if (!half) begin
        half = 1'b1;
        status &= ~STAT_DISPLAY;
        if (disp && mode_advances()) addr += {8'h00, regs[REG_HDISP]};
        if (row == regs[REG_VSYNC] && scan == 0) status |= STAT_VSYNC;
        return 1'b0;
      end
      half = 1'b0;
      if (disp) status |= STAT_DISPLAY;
      if (sync != 0) begin
        sync--;
        if (sync == 0) status &= ~STAT_VSYNC;
      end
      if (scan_match(regs[REG_CUR_END])) cur_line = 1'b0;
      if (adjust != 0) begin
        scan++;
        addr = row_start;
        adjust--;
        if (adjust == 0) begin
          disp = 1'b1;
          row_start = start_addr();
          addr = row_start;
          scan = '0;
        end
      end else if (scan_match(regs[REG_MAXSCAN])) begin
        prev = row;
        row_start = addr;
        scan = '0;
        row++;
        if (row == regs[REG_VDISP]) disp = 1'b0;
        if (prev == regs[REG_VTOTAL]) begin
          row = '0;
          adjust = regs[REG_VADJ][4:0];
          if (adjust == 0) begin
            disp = 1'b1;
            row_start = start_addr();
            addr = row_start;
          end
          if ((regs[REG_CUR_START] & 8'h60) == 8'h20) cur_blink = 1'b0;
          else cur_blink = blink[4];
        end
        if (row == regs[REG_VSYNC]) begin
          disp = 1'b0;
          sync = sync_reload;
          irq = 1'b1;
          blink++;
        end
      end else begin
        scan++;
        addr = row_start;
      end
      if (scan_match(regs[REG_CUR_START])) cur_line = 1'b1;
      return irq;
    endfunction

    function out_t advance_raster(in_t item);
      out_t r;
      r = '0;
      case (item.opcode)
        OP_WRITE: bus_write(item.port, item.wdata);
        OP_READ:  r.rdata = bus_read(item.port);
        OP_TICK:  r.vsync_irq = half_line_tick();
        default: ;
      endcase
      r.status = status;
      r.mem_address = addr;
      r.scanline = scan;
      r.row_count = row;
      r.display_enable = disp;
      r.cursor_visible = cur_line && cur_blink;
      return r;
    endfunction

    function void note_input(in_t item);
      due_results.push_back(advance_raster(item));
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch %0d at %0t: %s", errors, $realtime, msg);
    endtask

    task check_result(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result %h with nothing pending", got));
        return;
      end
      want = due_results.pop_front();
      if (got.rdata !== want.rdata)
        report($sformatf("rdata %h, want %h", got.rdata, want.rdata));
      if (got.status !== want.status)
        report($sformatf("status %h, want %h", got.status, want.status));
      if (got.mem_address !== want.mem_address)
        report($sformatf("mem_address %h, want %h", got.mem_address, want.mem_address));
      if (got.scanline !== want.scanline)
        report($sformatf("scanline %0d, want %0d", got.scanline, want.scanline));
      if (got.row_count !== want.row_count)
        report($sformatf("row_count %0d, want %0d", got.row_count, want.row_count));
      if (got.display_enable !== want.display_enable)
        report($sformatf("display_enable %b, want %b", got.display_enable,
                         want.display_enable));
      if (got.cursor_visible !== want.cursor_visible)
        report($sformatf("cursor_visible %b, want %b", got.cursor_visible,
                         want.cursor_visible));
      if (got.vsync_irq !== want.vsync_irq)
        report($sformatf("vsync_irq %b, want %b", got.vsync_irq, want.vsync_irq));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    items_sent;
  bit             hold_req;
  crtc_scoreboard raster;

  crtc_raster_timing_with_registers #(
    .VSYNC_HALF_LINES(VSYNC_HALF_LINES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: random stall, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) raster.check_result(out_data_o);
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 48;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_item(input in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    raster.note_input(item);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_op(input opcode_e op, input logic [3:0] p, input logic [7:0] d);
    in_t item;
    item.opcode = op;
    item.port   = p;
    item.wdata  = d;
    send_item(item);
  endtask

  // upper index bits are don't-care, so randomise them
  task automatic write_crtc(input logic [4:0] idx, input logic [7:0] v);
    send_op(OP_WRITE, PORT_INDEX, {3'($urandom), idx});
    send_op(OP_WRITE, PORT_DATA, v);
  endtask

  task automatic write_palette(input logic [4:0] idx, input logic [7:0] v);
    send_op(OP_READ, PORT_ARRAY, 8'($urandom));
    send_op(OP_WRITE, PORT_ARRAY, {3'($urandom), idx});
    send_op(OP_WRITE, PORT_ARRAY, v);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (raster.pending() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_burst(input int unsigned n);
    int unsigned first;
    int unsigned pick;
    logic [4:0]  idx;
    logic [7:0]  v;
    logic [6:0]  vt;
    first = items_sent;
    while (items_sent - first < n) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        repeat ($urandom_range(1, 8)) send_op(OP_TICK, 4'($urandom), 8'($urandom));
      end else if (pick < 50) begin
        vt = 7'($urandom_range(0, 5));
        write_crtc(REG_VTOTAL, {1'b0, vt});
        write_crtc(REG_VSYNC, 8'($urandom_range(0, vt)));
        write_crtc(REG_VDISP, 8'($urandom_range(0, vt + 1)));
        write_crtc(REG_MAXSCAN, 8'($urandom_range(0, 2)));
        write_crtc(REG_VADJ, 8'($urandom_range(0, 3)));
      end else if (pick < 65) begin
        idx = ($urandom_range(9) == 0) ? 5'($urandom_range(18, 31))
                                       : 5'($urandom_range(0, CRTC_REGS - 1));
        v = 8'($urandom);
        if ($urandom_range(9) != 0) begin
          case (idx)
            REG_VTOTAL, REG_VADJ, REG_VDISP, REG_VSYNC, REG_MAXSCAN:
              v = 8'($urandom_range(0, 4));
            default: ;
          endcase
        end
        write_crtc(idx, v);
      end else if (pick < 75) begin
        case ($urandom_range(3))
          0:       idx = 5'd0;
          1:       idx = 5'd3;
          default: idx = 5'($urandom);
        endcase
        write_palette(idx, 8'($urandom));
      end else if (pick < 88) begin
        case ($urandom_range(3))
          0: send_op(OP_READ, PORT_INDEX, 8'($urandom));
          1: begin
            send_op(OP_WRITE, PORT_INDEX, 8'($urandom));
            send_op(OP_READ, PORT_DATA, 8'($urandom));
          end
          2: send_op(OP_READ, PORT_ARRAY, 8'($urandom));
          default: send_op(OP_READ, 4'($urandom), 8'($urandom));
        endcase
      end else if (pick < 95) begin
        send_op(opcode_e'($urandom_range(3)), 4'($urandom), 8'($urandom));
      end else begin
        send_op(OP_READ, PORT_ARRAY, 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    hold_req      = 1'b0;
    items_sent    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    raster        = new(VSYNC_HALF_LINES);
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_op(OP_READ, PORT_INDEX, 8'h00);
    send_op(OP_WRITE, PORT_INDEX, 8'hff);
    send_op(OP_WRITE, PORT_DATA, 8'hff);
    send_op(OP_READ, PORT_DATA, 8'h00);
    send_op(OP_NONE, 4'hf, 8'hff);
    send_op(OP_WRITE, 4'h0, 8'haa);
    send_op(OP_READ, 4'hf, 8'h00);
    write_crtc(REG_INTERLACE, 8'hff);
    send_op(OP_READ, PORT_DATA, 8'h00);
    write_crtc(REG_HDISP, 8'h80);
    send_op(OP_WRITE, PORT_ARRAY, 8'h13);
    send_op(OP_WRITE, PORT_ARRAY, 8'hff);
    send_op(OP_READ, PORT_ARRAY, 8'h00);
    write_crtc(REG_MAXSCAN, 8'h03);
    write_crtc(REG_CUR_START, 8'h01);
    repeat (6) send_op(OP_TICK, 4'h0, 8'h00);

    send_idle_pct = 33;
    recv_idle_pct = 58;
    random_burst(460);
    wait_drained();

    send_idle_pct = 58;
    recv_idle_pct = 33;
    random_burst(460);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    random_burst(470);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (raster.errors == 0 && raster.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/crtc_rt_pkg.sv
rtl/core/crtc_raster_timing_with_registers.sv
verif/crtc_raster_timing_with_registers_tb.sv
